// ===== design/dscq_pkg.sv =====
// Types and codes shared by the deadline-sorted callout queue.
package dscq_pkg;

  localparam logic [2:0] REQ_INIT    = 3'd0;
  localparam logic [2:0] REQ_TERM    = 3'd1;
  localparam logic [2:0] REQ_START32 = 3'd2;
  localparam logic [2:0] REQ_START64 = 3'd3;
  localparam logic [2:0] REQ_STOP    = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_ALREADY  = 2'd2;
  localparam logic [1:0] ST_DUP_FULL = 2'd3;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [63:0]        entry_handle;
    logic signed [63:0] delay_value;
    logic signed [63:0] now_time;
    logic [63:0]        handler_word;
    logic [63:0]        argument_word;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found_reported;
    logic       found_flag;
    logic [8:0] queue_count;
  } out_t;

  typedef struct packed {
    logic [63:0]        handle;
    logic signed [63:0] deadline;
    logic [63:0]        handler;
    logic [63:0]        argument;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHUP,
    S_SHDN,
    S_PUT,
    S_RESP
  } state_t;

endpackage

// ===== design/deadline_sorted_callout_queue_top.sv =====
// Deadline-sorted callout queue: top level with entry memory and sequencer.
//
// Entries live in one synchronous memory, kept in ascending deadline order.
// One transaction is handled at a time. Init, term and rejected requests go
// straight to the response state. Start scans every queued entry once (one
// memory read per cycle, for the duplicate check and the insert position),
// then moves each entry behind the insert position up one slot (one read and
// one write per cycle), then writes the new entry. Stop scans up to the
// matching entry and moves the entries behind it down one slot. The single
// memory port pair sets the pace of each step. A finished result waits in an
// output register, and the next transaction can be taken while it waits.
module deadline_sorted_callout_queue_top #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dscq_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dscq_pkg::out_t out_data
);
  import dscq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // entry memory
  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] wa;
  entry_t        wd;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  state_t state_r, state_nxt;
  in_t           req_r, req_nxt;
  logic signed [63:0] dl_r, dl_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          active_r, active_nxt;
  logic [AW-1:0] sc_r, sc_nxt;       // index whose data is in rd_data_r
  logic [AW-1:0] pos_r, pos_nxt;
  logic          pos_v_r, pos_v_nxt;
  logic          dup_r, dup_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          rep_r, rep_nxt;
  logic          fnd_r, fnd_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_r, out_nxt;

  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] last_idx;
  logic [CW+8:0] cnt_ext;
  logic [63:0]   delay_u;
  logic          hit;
  logic          ge;
  logic [AW-1:0] ins_pos;

  assign cnt_m1   = cnt_r - 1'b1;
  assign last_idx = cnt_m1[AW-1:0];
  assign cnt_ext  = {9'd0, cnt_r};
  assign delay_u  = (in_data.req_type == REQ_START32) ?
                    {32'd0, in_data.delay_value[31:0]} : in_data.delay_value;
  assign hit      = (rd_data_r.handle == req_r.entry_handle);
  assign ge       = (rd_data_r.deadline >= dl_r);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    dl_nxt        = dl_r;
    cnt_nxt       = cnt_r;
    active_nxt    = active_r;
    sc_nxt        = sc_r;
    pos_nxt       = pos_r;
    pos_v_nxt     = pos_v_r;
    dup_nxt       = dup_r;
    status_nxt    = status_r;
    rep_nxt       = rep_r;
    fnd_nxt       = fnd_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_nxt       = out_r;
    rd_addr       = '0;
    we            = 1'b0;
    wa            = pos_r;
    wd            = rd_data_r;
    ins_pos       = pos_v_r ? pos_r : cnt_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_data;
          dl_nxt     = in_data.now_time + delay_u;
          status_nxt = ST_OK;
          rep_nxt    = 1'b0;
          fnd_nxt    = 1'b0;
          sc_nxt     = '0;
          pos_nxt    = '0;
          pos_v_nxt  = 1'b0;
          dup_nxt    = 1'b0;
          state_nxt  = S_RESP;
          if (in_data.req_type == REQ_INIT) begin
            if (active_r) begin
              status_nxt = ST_ALREADY;
            end else begin
              active_nxt = 1'b1;
              cnt_nxt    = '0;
            end
          end else if (in_data.req_type > REQ_STOP || !active_r) begin
            status_nxt = ST_INVALID;
          end else if (in_data.req_type == REQ_TERM) begin
            active_nxt = 1'b0;
            cnt_nxt    = '0;
          end else if (in_data.entry_handle == '0) begin
            status_nxt = ST_INVALID;
          end else if (in_data.req_type == REQ_STOP) begin
            rep_nxt = (in_data.delay_value != '0);
            if (cnt_r != '0) begin
              state_nxt = S_SCAN;
            end
          end else if (cnt_r >= CW'(QUEUE_DEPTH)) begin
            status_nxt = ST_DUP_FULL;
          end else if (cnt_r == '0) begin
            state_nxt = S_PUT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_addr = sc_r + 1'b1;
        sc_nxt  = sc_r + 1'b1;
        if (req_r.req_type == REQ_STOP) begin
          if (hit) begin
            // drop the match; pull later entries down
            fnd_nxt = rep_r;
            cnt_nxt = cnt_m1;
            if (sc_r == last_idx) begin
              state_nxt = S_RESP;
            end else begin
              state_nxt = S_SHDN;
            end
          end else if (sc_r == last_idx) begin
            state_nxt = S_RESP;
          end
        end else begin
          if (!pos_v_r && ge) begin
            pos_nxt   = sc_r;
            pos_v_nxt = 1'b1;
          end
          if (hit) begin
            dup_nxt = 1'b1;
          end
          if (sc_r == last_idx) begin
            ins_pos = (!pos_v_r && ge) ? sc_r : (pos_v_r ? pos_r : cnt_r[AW-1:0]);
            pos_nxt = ins_pos;
            if (dup_r || hit) begin
              status_nxt = ST_DUP_FULL;
              state_nxt  = S_RESP;
            end else if (pos_v_r || ge) begin
              // open a slot: move entries from the tail upward
              rd_addr   = last_idx;
              sc_nxt    = last_idx;
              state_nxt = S_SHUP;
            end else begin
              state_nxt = S_PUT;
            end
          end
        end
      end
      S_SHUP: begin
        we = 1'b1;
        wa = sc_r + 1'b1;
        if (sc_r == pos_r) begin
          state_nxt = S_PUT;
        end else begin
          rd_addr = sc_r - 1'b1;
          sc_nxt  = sc_r - 1'b1;
        end
      end
      S_SHDN: begin
        // sc_r holds the index of the entry read; cnt_r is already decremented
        we = 1'b1;
        wa = sc_r - 1'b1;
        if (sc_r == cnt_r[AW-1:0]) begin
          state_nxt = S_RESP;
        end else begin
          rd_addr = sc_r + 1'b1;
          sc_nxt  = sc_r + 1'b1;
        end
      end
      S_PUT: begin
        we          = 1'b1;
        wa          = pos_r;
        wd.handle   = req_r.entry_handle;
        wd.deadline = dl_r;
        wd.handler  = req_r.handler_word;
        wd.argument = req_r.argument_word;
        cnt_nxt     = cnt_r + 1'b1;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_nxt.status         = status_r;
          out_nxt.found_reported = (status_r == ST_OK) && rep_r;
          out_nxt.found_flag     = (status_r == ST_OK) && fnd_r;
          out_nxt.queue_count    = cnt_ext[8:0];
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r    <= req_nxt;
    dl_r     <= dl_nxt;
    sc_r     <= sc_nxt;
    pos_r    <= pos_nxt;
    pos_v_r  <= pos_v_nxt;
    dup_r    <= dup_nxt;
    status_r <= status_nxt;
    rep_r    <= rep_nxt;
    fnd_r    <= fnd_nxt;
    out_r    <= out_nxt;
  end

endmodule
